// ===== design/srr_pkg.sv =====
package srr_pkg;

  localparam int SEQ_W     = 10;  // seq field width
  localparam int CNT_W     = 11;  // frame counts, pointer, ack
  localparam int IDX_W     = 2;   // config register index
  localparam int S_DATA_W  = 16;  // seq padded to whole bytes
  localparam int M_DATA_W  = 16;  // ack_value padded to whole bytes

  localparam logic [IDX_W-1:0] REG_WINDOW_SIZE  = 2'd0;
  localparam logic [IDX_W-1:0] REG_TOTAL_FRAMES = 2'd1;

  localparam logic [CNT_W-1:0] WINDOW_RESET = 11'd8;
  localparam logic [CNT_W-1:0] TOTAL_RESET  = 11'd1024;
  localparam logic signed [CNT_W-1:0] NO_ACK = -11'sd1;

  typedef struct packed {
    logic signed [CNT_W-1:0] ack_value;
    logic                    done_res;
  } result_t;

endpackage

// ===== design/srr_bitmap.sv =====
module srr_bitmap
  import srr_pkg::*;
#(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          mark,
  input  logic [AW-1:0] mark_addr,
  input  logic [AW-1:0] rd_addr,
  output logic          rd_data,
  output logic          ready
);

  localparam logic [AW-1:0] LastAddr = AW'(DEPTH - 1);

  logic          mem [DEPTH];
  logic          clearing;
  logic [AW-1:0] clr_addr;

  // clearing pass after reset, one entry per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == LastAddr) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= 1'b0;
    end else if (mark) begin
      mem[mark_addr] <= 1'b1;
    end
    rd_data <= mem[rd_addr];
  end

  assign ready = !clearing;

endmodule

// ===== design/srr_ctrl.sv =====
module srr_ctrl
  import srr_pkg::*;
#(
  parameter int MAX_FRAMES = 1024,
  parameter int DEPTH      = 1024,
  parameter int AW         = 10
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [CNT_W-1:0] window_size,
  input  logic [CNT_W-1:0] total_frames,
  input  logic             map_ready,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [SEQ_W-1:0] in_seq,
  output logic             mark,
  output logic [AW-1:0]    mark_addr,
  output logic [AW-1:0]    rd_addr,
  input  logic             rd_data,
  output logic             res_valid,
  input  logic             res_ready,
  output result_t          res
);

  localparam int MaxLimInt = (MAX_FRAMES > 2047) ? 2047 : MAX_FRAMES;
  localparam logic [CNT_W-1:0] MaxLim   = CNT_W'(MaxLimInt);
  localparam logic [CNT_W-1:0] DepthCnt = CNT_W'(DEPTH);

  typedef enum logic [2:0] {IDLE, CHECK, RD, CHK, EMIT} state_t;

  state_t                  state;
  logic [SEQ_W-1:0]        seq;
  logic [CNT_W-1:0]        next_expected;
  logic signed [CNT_W-1:0] last_ack;

  logic [CNT_W-1:0] lim;
  logic [CNT_W-1:0] seq_ext;
  logic [CNT_W-1:0] span;
  logic             beyond;
  logic             ahead;
  logic             too_far;
  logic             can_walk;

  always_comb begin
    lim      = (total_frames > MaxLim) ? MaxLim : total_frames;
    seq_ext  = CNT_W'(seq);
    span     = seq_ext - next_expected;
    beyond   = seq_ext >= lim;
    ahead    = seq_ext >= next_expected;
    too_far  = ahead && (span > window_size);
    can_walk = (next_expected < lim) && (next_expected < DepthCnt);
  end

  assign in_ready  = (state == IDLE) && map_ready;
  assign mark      = (state == CHECK) && !beyond && !too_far;
  assign mark_addr = seq[AW-1:0];
  assign rd_addr   = next_expected[AW-1:0];
  assign res_valid = (state == EMIT);
  assign res.ack_value = last_ack;
  assign res.done_res  = next_expected >= lim;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= IDLE;
      next_expected <= '0;
      last_ack      <= NO_ACK;
    end else begin
      case (state)
        IDLE: begin
          if (in_valid && in_ready) begin
            seq   <= in_seq;
            state <= CHECK;
          end
        end
        CHECK: begin
          if (beyond || too_far) begin
            state <= IDLE;
          end else if (ahead) begin
            state <= RD;
          end else begin
            state <= EMIT;
          end
        end
        RD: begin
          // mark from CHECK is already in the memory here
          state <= can_walk ? CHK : EMIT;
        end
        CHK: begin
          if (rd_data) begin
            last_ack      <= $signed(next_expected);
            next_expected <= next_expected + 1'b1;
            state         <= RD;
          end else begin
            state <= EMIT;
          end
        end
        EMIT: begin
          if (res_ready) begin
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

// ===== design/selective_repeat_receiver.sv =====
// Selective-repeat receiver with cumulative ack.
// Slave stream (s_*): one frame sequence number per transfer in s_tdata.
// Master stream (m_*): one result per accepted frame, the cumulative ack in
//   m_tdata[10:0] (11-bit two's complement, zero-padded above, -1 before any
//   in-order frame) and the done flag in m_tuser. Frames outside the
//   transfer or beyond the window give no result.
// Config channel (cfg_*): index 0 window_size, index 1 total_frames; write
//   only while the block is idle. Always ready.
// States: a duplicate goes from CHECK to EMIT, then to the output register;
//   an in-window frame goes from CHECK through RD and CHK steps to EMIT, one
//   RD and CHK pair for each frame the next-expected pointer walks over,
//   since each step is one read of the received bitmap and one check of its
//   data. A dropped frame goes from CHECK back to IDLE, which frees the
//   input. One frame is in work at a time; the output register lets the
//   next frame be taken while the result waits.
// Reset: after rst the bitmap is cleared one entry per cycle (the smaller of
//   MAX_FRAMES and 1024 entries); s_tready stays low during that pass.
// A stalled master side holds m_tvalid and the result; the next frame is
//   worked on and its result waits until the register is free.
module selective_repeat_receiver
  import srr_pkg::*;
#(
  parameter int MAX_FRAMES = 1024
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [S_DATA_W-1:0] s_tdata,   // [9:0] seq
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [M_DATA_W-1:0] m_tdata,   // [10:0] ack_value
  output logic                m_tuser,   // [0] done_res
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [IDX_W-1:0]    cfg_index,
  input  logic [CNT_W-1:0]    cfg_data
);

  localparam int MemDepth = (MAX_FRAMES < 1024) ? MAX_FRAMES : 1024;
  localparam int Aw       = (MemDepth > 1) ? $clog2(MemDepth) : 1;

  logic [CNT_W-1:0] window_size;
  logic [CNT_W-1:0] total_frames;

  logic          map_ready;
  logic          mark;
  logic [Aw-1:0] mark_addr;
  logic [Aw-1:0] rd_addr;
  logic          rd_data;
  logic          res_valid;
  logic          res_ready;
  result_t       res;
  result_t       out_res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size  <= WINDOW_RESET;
      total_frames <= TOTAL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_WINDOW_SIZE:  window_size  <= cfg_data;
        REG_TOTAL_FRAMES: total_frames <= cfg_data;
        default: ;
      endcase
    end
  end

  srr_bitmap #(
    .DEPTH (MemDepth),
    .AW    (Aw)
  ) u_bitmap (
    .clk       (clk),
    .rst       (rst),
    .mark      (mark),
    .mark_addr (mark_addr),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .ready     (map_ready)
  );

  srr_ctrl #(
    .MAX_FRAMES (MAX_FRAMES),
    .DEPTH      (MemDepth),
    .AW         (Aw)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .window_size  (window_size),
    .total_frames (total_frames),
    .map_ready    (map_ready),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .in_seq       (s_tdata[SEQ_W-1:0]),
    .mark         (mark),
    .mark_addr    (mark_addr),
    .rd_addr      (rd_addr),
    .rd_data      (rd_data),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res          (res)
  );

  // output register
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_res <= res;
    end
  end

  assign m_tdata = {{(M_DATA_W - CNT_W){1'b0}}, out_res.ack_value};
  assign m_tuser = out_res.done_res;

endmodule

// ===== tb/selective_repeat_receiver_test.sv =====
`timescale 1ns / 100ps
module selective_repeat_receiver_test;
  import srr_pkg::*;

  localparam int MAX_FRAMES    = 1024;
  localparam int LIVE_TARGET   = 1900;
  localparam int SETTLE_CYCLES = 16;
  localparam int QUIET_LIMIT   = 20000;

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                s_tvalid  = 1'b0;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata   = '0;   // [9:0] seq
  logic                m_tvalid;
  logic                m_tready  = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;          // [10:0] ack_value
  logic                m_tuser;          // [0] done_res
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [IDX_W-1:0]    cfg_index = '0;
  logic [CNT_W-1:0]    cfg_data  = '0;

  // expected receiver state and register copies
  logic                    seen_map [MAX_FRAMES];
  logic [CNT_W-1:0]        exp_next;
  logic signed [CNT_W-1:0] exp_ack;
  logic [CNT_W-1:0]        exp_window;
  logic [CNT_W-1:0]        exp_total;
  result_t                 ack_q [$];

  logic [SEQ_W-1:0] frame_q [$];
  bit frame_taken  = 1'b0;
  bit tx_busy      = 1'b0;
  bit tx_idle_en   = 1'b1;
  bit rx_idle_en   = 1'b1;
  int tx_gap       = 0;
  int rx_hold      = 0;
  int n_err        = 0;
  int n_live       = 0;
  int quiet_cycles = 0;

  selective_repeat_receiver #(
    .MAX_FRAMES(MAX_FRAMES)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Returns 1 when the frame is taken; res then holds the ack it causes.
  function automatic bit take_frame(input logic [SEQ_W-1:0] seq, output result_t res);
    logic [CNT_W-1:0] lim;
    logic [CNT_W-1:0] seq_w;
    lim   = (exp_total > MAX_FRAMES) ? CNT_W'(MAX_FRAMES) : exp_total;
    seq_w = {1'b0, seq};
    res   = '0;
    if (seq_w >= lim) return 1'b0;
    if (seq_w >= exp_next) begin
      if (seq_w - exp_next > exp_window) return 1'b0;
      seen_map[seq] = 1'b1;
      while (exp_next < lim && seen_map[exp_next[SEQ_W-1:0]]) begin
        exp_ack  = exp_next;
        exp_next = exp_next + 1'b1;
      end
    end else begin
      seen_map[seq] = 1'b1;
    end
    res.ack_value = exp_ack;
    res.done_res  = (exp_next >= lim);
    return 1'b1;
  endfunction

  task automatic queue_frame(input int seq);
    frame_q.push_back(SEQ_W'(seq));
  endtask

  // dup_top: every frame below it is already behind the pointer
  // ahead: the pointer is at most here while this frame waits
  task automatic queue_noise(input int dup_top, input int ahead, input int lim, input int w);
    int top;
    int seq;
    top = (dup_top < lim) ? dup_top : lim;
    case ($urandom_range(0, 9))
      0, 1: begin
        seq = ahead + w + 1 + $urandom_range(0, 40);
        if (seq < MAX_FRAMES) queue_frame(seq);
      end
      2: if (lim < MAX_FRAMES) queue_frame($urandom_range(lim, MAX_FRAMES - 1));
      default: if (top > 0) begin
        queue_frame($urandom_range(0, top - 1));
        n_live++;
      end
    endcase
  endtask

  // Fresh frames go out in shuffled chunks no wider than the window, so all of
  // them are taken; duplicates and dropped frames are mixed in between.
  task automatic plan_phase(input int nfresh);
    int lim, w, base, stop, k, j, r, t, hold;
    int perm [$];
    lim  = (exp_total > MAX_FRAMES) ? MAX_FRAMES : int'(exp_total);
    w    = int'(exp_window);
    base = int'(exp_next);
    stop = (base + nfresh < lim) ? base + nfresh : lim;
    if (base >= stop) begin
      repeat ($urandom_range(20, 60)) queue_noise(base, base, lim, w);
    end
    while (base < stop) begin
      k = $urandom_range(1, (w >= 256) ? 300 : 12);
      if (k > w + 1) k = w + 1;
      if (k > stop - base) k = stop - base;
      perm.delete();
      for (j = 1; j < k; j++) perm.push_back(base + j);
      perm.push_back(base);
      // lowest frame held last when hold is 1: the pointer then walks the whole chunk at once
      hold = $urandom_range(0, 1);
      for (j = k - 1 - hold; j > 0; j--) begin
        r = $urandom_range(0, j);
        t = perm[j];
        perm[j] = perm[r];
        perm[r] = t;
      end
      for (j = 0; j < k; j++) begin
        queue_frame(perm[j]);
        n_live++;
        if ($urandom_range(0, 9) < 4) queue_noise(base, base + k, lim, w);
      end
      base += k;
    end
  endtask

  task automatic write_regs(input logic [CNT_W-1:0] win, input logic [CNT_W-1:0] frames);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= REG_WINDOW_SIZE;
    cfg_data  <= win;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_index <= REG_TOTAL_FRAMES;
    cfg_data  <= frames;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // hold off until every frame is sent and every ack is back
  task automatic settle();
    while (frame_q.size() != 0 || tx_busy || ack_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  always @(negedge clk) begin
    if (frame_taken) begin
      frame_taken = 1'b0;
      tx_busy     = 1'b0;
    end
    if (!rst && !tx_busy) begin
      if (tx_gap > 0) begin
        tx_gap--;
      end else if (frame_q.size() != 0) begin
        s_tdata <= {{(S_DATA_W-SEQ_W){1'b0}}, frame_q.pop_front()};
        tx_busy = 1'b1;
        tx_gap  = tx_idle_en ? $urandom_range(0, 10) : 0;
      end
    end
    s_tvalid <= tx_busy;
  end

  always @(negedge clk) begin
    if (rx_hold > 0) begin
      rx_hold--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    result_t want;
    result_t got;
    if (rst) begin
      for (int i = 0; i < MAX_FRAMES; i++) seen_map[i] = 1'b0;
      exp_next   = '0;
      exp_ack    = NO_ACK;
      exp_window = WINDOW_RESET;
      exp_total  = TOTAL_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_WINDOW_SIZE) exp_window = cfg_data;
        else if (cfg_index == REG_TOTAL_FRAMES) exp_total = cfg_data;
      end
      if (s_tvalid && s_tready) begin
        frame_taken = 1'b1;
        if (take_frame(s_tdata[SEQ_W-1:0], want)) ack_q.push_back(want);
      end
      if (m_tvalid && m_tready) begin
        rx_hold = rx_idle_en ? $urandom_range(0, 10) : 0;
        got.ack_value = m_tdata[CNT_W-1:0];
        got.done_res  = m_tuser;
        if (ack_q.size() == 0) begin
          n_err++;
          if (n_err <= 10)
            $display("unexpected ack transfer: ack %0d done %0b", got.ack_value, got.done_res);
        end else begin
          want = ack_q.pop_front();
          if (got.ack_value !== want.ack_value || got.done_res !== want.done_res) begin
            n_err++;
            if (n_err <= 10)
              $display("ack mismatch: expected ack %0d done %0b, got ack %0d done %0b",
                       want.ack_value, want.done_res, got.ack_value, got.done_res);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("selective_repeat_receiver_test: errors");
        $finish;
      end
    end
  end

  initial begin
    int p;
    int r;
    logic [CNT_W-1:0] win;
    logic [CNT_W-1:0] tot;
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    // in order, repeat, far ahead, window edge, one past it, gap filled last
    write_regs(WINDOW_RESET, TOTAL_RESET);
    queue_frame(0); queue_frame(0); queue_frame(1023); queue_frame(9);
    queue_frame(10); queue_frame(3); queue_frame(2); queue_frame(1);
    settle();
    write_regs('0, TOTAL_RESET);   // zero window
    queue_frame(5); queue_frame(4); queue_frame(4);
    settle();
    write_regs('1, 11'd6);         // transfer ends at frame 5
    queue_frame(5); queue_frame(6); queue_frame(2);
    settle();
    write_regs('1, 11'd3);         // count now below the pointer
    queue_frame(2); queue_frame(3);
    settle();
    write_regs('1, 11'd1);
    queue_frame(0);
    settle();
    write_regs('1, '0);
    queue_frame(0);
    settle();
    write_regs('1, '1);            // count above the bitmap size
    queue_frame(1023); queue_frame(6);
    settle();

    for (p = 0; n_live < LIVE_TARGET; p++) begin
      case (p % 6)
        0:       win = CNT_W'($urandom_range(1, 4));
        1:       win = '0;
        2:       win = CNT_W'($urandom_range(5, 16));
        3:       win = 11'd1024;
        4:       win = '1;
        default: win = CNT_W'($urandom_range(17, 200));
      endcase
      r = $urandom_range(0, 9);
      if (r < 5) begin
        tot = 11'd1024;
      end else if (r < 7) begin
        tot = '1;
      end else if (r < 9) begin
        tot = CNT_W'(int'(exp_next) + $urandom_range(1, 40));
        if (tot > 11'd1024) tot = 11'd1024;
      end else begin
        tot = CNT_W'($urandom_range(0, int'(exp_next)));
      end
      tx_idle_en = ($urandom_range(0, 3) != 0);
      rx_idle_en = ($urandom_range(0, 3) != 0);
      write_regs(win, tot);
      plan_phase((win >= 256) ? $urandom_range(80, 300) : $urandom_range(15, 60));
      settle();
    end

    if (n_err == 0 && ack_q.size() == 0) begin
      $display("selective_repeat_receiver_test: clean");
    end else begin
      $display("selective_repeat_receiver_test: errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/srr_pkg.sv
design/srr_bitmap.sv
design/srr_ctrl.sv
design/selective_repeat_receiver.sv
tb/selective_repeat_receiver_test.sv
